FILE: rtl/core/obdpr_pkg.sv
// ----------------------------------------------------------------------------
// obdpr_pkg
// Shared types, constants and helpers of the OBD mode 01 PID responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obdpr_pkg;

  // Field widths
  localparam int IdW     = 11;
  localparam int LenW    = 4;
  localparam int ByteW   = 8;
  localparam int RpmW    = 16;
  localparam int ThrW    = 7;
  localparam int PeriodW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  // Parameter defaults
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CMDQ_DEPTH_DEF  = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FUNC_ID    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHYS_ID    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_ID   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ENG_PERIOD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VEH_PERIOD = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BODY_PERIOD = 3'd5;

  // Configuration reset values
  localparam logic [IdW-1:0]     FUNC_ID_RST     = 11'h7DF;
  localparam logic [IdW-1:0]     PHYS_ID_RST     = 11'h7E0;
  localparam logic [IdW-1:0]     REPLY_ID_RST    = 11'h7E8;
  localparam logic [PeriodW-1:0] ENG_PERIOD_RST  = 16'd20;
  localparam logic [PeriodW-1:0] VEH_PERIOD_RST  = 16'd50;
  localparam logic [PeriodW-1:0] BODY_PERIOD_RST = 16'd500;

  // Broadcast identifiers
  localparam logic [IdW-1:0] ID_ENGINE  = 11'h120;
  localparam logic [IdW-1:0] ID_VEHICLE = 11'h180;
  localparam logic [IdW-1:0] ID_BODY    = 11'h220;

  // Service and PID codes
  localparam logic [ByteW-1:0] MODE_CUR_DATA = 8'h01;
  localparam logic [ByteW-1:0] MODE_REPLY    = 8'h41;
  localparam logic [ByteW-1:0] PID_SUPPORTED = 8'h00;
  localparam logic [ByteW-1:0] PID_COOLANT   = 8'h05;
  localparam logic [ByteW-1:0] PID_RPM       = 8'h0C;
  localparam logic [ByteW-1:0] PID_VSS       = 8'h0D;
  localparam logic [ByteW-1:0] PID_TPS       = 8'h11;
  localparam logic [LenW-1:0]  MIN_REQ_LEN   = 4'd3;

  // Supported-PID bitmap bytes
  localparam logic [ByteW-1:0] SUPP_B0 = 8'h08;
  localparam logic [ByteW-1:0] SUPP_B1 = 8'h18;
  localparam logic [ByteW-1:0] SUPP_B2 = 8'h80;
  localparam logic [ByteW-1:0] SUPP_B3 = 8'h00;

  localparam logic [ByteW-1:0] COOLANT_OFS = 8'd40;

  // Broadcast mask bit positions
  localparam int BC_ENGINE  = 0;
  localparam int BC_VEHICLE = 1;
  localparam int BC_BODY    = 2;
  localparam int BcW        = 3;

  // One unit of work handed from the front to the back
  typedef struct packed {
    logic             is_reply;
    logic [ByteW-1:0] pid;
    logic [BcW-1:0]   bcast;
    logic [RpmW-1:0]  rpm;
    logic [ByteW-1:0] speed;
    logic [ThrW-1:0]  throttle;
    logic [ByteW-1:0] coolant;
  } cmd_t;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // throttle * 255 / 100, low 8 bits; 1/100 as 5243 / 2^19 (exact below 43699)
  function automatic logic [ByteW-1:0] thr_scale(input logic [ThrW-1:0] t);
    logic [14:0] p;
    logic [27:0] m;
    p = 15'({t, 8'b0}) - 15'(t);
    m = 28'(p) * 28'd5243;
    return m[26:19];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/obdpr_cmdq.sv
// ----------------------------------------------------------------------------
// obdpr_cmdq
// Small FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obdpr_cmdq #(
  parameter int Depth = obdpr_pkg::CMDQ_DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire obdpr_pkg::cmd_t wdata_i,
  input  wire logic            pop_i,
  output obdpr_pkg::cmd_t      rdata_o,
  output obdpr_pkg::q_stat_t   stat_o
);
  import obdpr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = slots_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/obdpr_front.sv
// ----------------------------------------------------------------------------
// obdpr_front
// Accepts requests, filters OBD requests, runs the broadcast period timers
// and hands each item that yields frames to the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obdpr_front #(
  parameter int TIMER_WIDTH = obdpr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic                           kind_i,
  input  wire logic [obdpr_pkg::IdW-1:0]      can_id_i,
  input  wire logic [obdpr_pkg::LenW-1:0]     frame_len_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]    mode_byte_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]    pid_byte_i,
  input  wire logic [obdpr_pkg::RpmW-1:0]     engine_rpm_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]    road_speed_i,
  input  wire logic [obdpr_pkg::ThrW-1:0]     throttle_percent_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]    coolant_temp_i,
  input  wire logic [obdpr_pkg::IdW-1:0]      func_id_i,
  input  wire logic [obdpr_pkg::IdW-1:0]      phys_id_i,
  input  wire logic [obdpr_pkg::PeriodW-1:0]  eng_period_i,
  input  wire logic [obdpr_pkg::PeriodW-1:0]  veh_period_i,
  input  wire logic [obdpr_pkg::PeriodW-1:0]  body_period_i,
  output logic                                push_o,
  output obdpr_pkg::cmd_t                     cmd_o
);
  import obdpr_pkg::*;

  localparam int CmpW = (TIMER_WIDTH > PeriodW) ? TIMER_WIDTH : PeriodW;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  logic [TIMER_WIDTH-1:0] elapsed_q [BcW];
  logic [TIMER_WIDTH-1:0] elapsed_d [BcW];
  logic [PeriodW-1:0]     period [BcW];
  logic [TIMER_WIDTH-1:0] bumped [BcW];
  logic [BcW-1:0]         hit;
  logic                   id_ok, req_ok, pid_ok;

  assign period[BC_ENGINE]  = eng_period_i;
  assign period[BC_VEHICLE] = veh_period_i;
  assign period[BC_BODY]    = body_period_i;

  // Request filter
  always_comb begin
    id_ok  = (can_id_i == func_id_i) || (can_id_i == phys_id_i);
    req_ok = id_ok && (frame_len_i >= MIN_REQ_LEN) && (mode_byte_i == MODE_CUR_DATA);
    case (pid_byte_i)
      PID_SUPPORTED, PID_COOLANT, PID_RPM, PID_VSS, PID_TPS: pid_ok = 1'b1;
      default:                                              pid_ok = 1'b0;
    endcase
  end

  // Period timers: saturating count, restart on reaching the period
  always_comb begin
    for (int i = 0; i < BcW; i++) begin
      bumped[i]    = (elapsed_q[i] == TimerMax) ? elapsed_q[i] : elapsed_q[i] + 1'b1;
      hit[i]       = CmpW'(bumped[i]) >= CmpW'(period[i]);
      elapsed_d[i] = elapsed_q[i];
      if (accept_i && kind_i) begin
        elapsed_d[i] = hit[i] ? '0 : bumped[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BcW; i++) begin
        elapsed_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < BcW; i++) begin
        elapsed_q[i] <= elapsed_d[i];
      end
    end
  end

  // Command toward the back
  always_comb begin
    cmd_o.is_reply = !kind_i;
    cmd_o.pid      = pid_byte_i;
    cmd_o.bcast    = kind_i ? hit : '0;
    cmd_o.rpm      = engine_rpm_i;
    cmd_o.speed    = road_speed_i;
    cmd_o.throttle = throttle_percent_i;
    cmd_o.coolant  = coolant_temp_i;
    push_o = accept_i && (kind_i ? (hit != '0) : (req_ok && pid_ok));
  end

endmodule

`default_nettype wire

FILE: rtl/core/obdpr_back.sv
// ----------------------------------------------------------------------------
// obdpr_back
// Turns queued commands into 8-byte frames, one per cycle while the queue
// has a command and the output register, which the consumer drains, is empty or popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obdpr_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire obdpr_pkg::cmd_t             cmd_i,
  input  wire logic                        cmd_empty_i,
  output logic                             cmd_pop_o,
  input  wire logic [obdpr_pkg::IdW-1:0]   reply_id_i,
  input  wire logic                        pop_i,
  output logic                             out_valid_o,
  output logic [obdpr_pkg::IdW-1:0]        frame_id_o,
  output logic [obdpr_pkg::ByteW-1:0]      data_o [8],
  output logic                             last_o
);
  import obdpr_pkg::*;

  logic [BcW-1:0]   sent_q, sent_d;
  logic [BcW-1:0]   remain, sel;
  logic             last, load;
  logic             out_valid_q;
  logic [IdW-1:0]   frame_id_q, frame_id_d;
  logic [ByteW-1:0] data_q [8];
  logic [ByteW-1:0] data_d [8];
  logic             last_q;
  logic [RpmW-1:0]  rpm4, centi;
  logic [ByteW-1:0] cool_b, thr_b;

  // Pick the next frame of the head command
  always_comb begin
    remain    = cmd_i.bcast & ~sent_q;
    sel       = remain & (~remain + 1'b1);
    last      = cmd_i.is_reply || ((remain & ~sel) == '0);
    load      = !cmd_empty_i && (!out_valid_q || pop_i);
    cmd_pop_o = load && last;
    sent_d    = sent_q;
    if (load) begin
      sent_d = last ? '0 : (sent_q | sel);
    end
  end

  // Scaled values
  always_comb begin
    rpm4   = {cmd_i.rpm[RpmW-3:0], 2'b00};
    cool_b = cmd_i.coolant + COOLANT_OFS;
    thr_b  = thr_scale(cmd_i.throttle);
    centi  = RpmW'(cmd_i.speed) * RpmW'(100);
  end

  // Frame contents
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      data_d[j] = '0;
    end
    frame_id_d = reply_id_i;
    if (cmd_i.is_reply) begin
      data_d[1] = MODE_REPLY;
      data_d[2] = cmd_i.pid;
      case (cmd_i.pid)
        PID_SUPPORTED: begin
          data_d[0] = 8'd6;
          data_d[3] = SUPP_B0;
          data_d[4] = SUPP_B1;
          data_d[5] = SUPP_B2;
          data_d[6] = SUPP_B3;
        end
        PID_COOLANT: begin
          data_d[0] = 8'd3;
          data_d[3] = cool_b;
        end
        PID_RPM: begin
          data_d[0] = 8'd4;
          data_d[3] = rpm4[15:8];
          data_d[4] = rpm4[7:0];
        end
        PID_VSS: begin
          data_d[0] = 8'd3;
          data_d[3] = cmd_i.speed;
        end
        default: begin
          data_d[0] = 8'd3;
          data_d[3] = thr_b;
        end
      endcase
    end else if (sel[BC_ENGINE]) begin
      frame_id_d = ID_ENGINE;
      data_d[0]  = rpm4[15:8];
      data_d[1]  = rpm4[7:0];
      data_d[2]  = cool_b;
      data_d[3]  = thr_b;
    end else if (sel[BC_VEHICLE]) begin
      frame_id_d = ID_VEHICLE;
      data_d[0]  = centi[15:8];
      data_d[1]  = centi[7:0];
      data_d[2]  = {7'b0, cmd_i.speed != '0};
    end else begin
      frame_id_d = ID_BODY;
      data_d[0]  = {7'b0, cmd_i.speed == '0};
      data_d[1]  = {7'b0, cmd_i.speed != '0};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else begin
      sent_q <= sent_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_id_q <= frame_id_d;
      last_q     <= last;
      for (int j = 0; j < 8; j++) begin
        data_q[j] <= data_d[j];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_id_o  = frame_id_q;
  assign last_o      = last_q;
  assign data_o      = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/obd_pid_responder_with_broadcasts_top.sv
// ----------------------------------------------------------------------------
// obd_pid_responder_with_broadcasts_top
// OBD mode 01 PID responder with periodic engine, vehicle and body frames.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | kind, can_id, frame_len, mode/pid, values
//   result   | empty / pop      | frame_id, data0..data7, last_of_run
//   config   | cfg_we_i         | cfg_idx_i, cfg_wdata_i (no read-back)
//
// One request is taken per cycle while the command queue has room.
// The frame builder emits one frame per cycle while its output is empty or
// popped, so a tick that fires all three broadcasts yields three frames; a
// reply yields one. The first frame of a request passes the command queue
// and then the output register before it reaches the result ports.
// Reset loads the register defaults and zeroes the period timers; no
// clearing pass. A stalled result only backs up the queue, then full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obd_pid_responder_with_broadcasts_top #(
  parameter int TIMER_WIDTH = obdpr_pkg::TIMER_WIDTH_DEF,
  parameter int CMDQ_DEPTH  = obdpr_pkg::CMDQ_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          kind_i,
  input  wire logic [obdpr_pkg::IdW-1:0]     can_id_i,
  input  wire logic [obdpr_pkg::LenW-1:0]    frame_len_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]   mode_byte_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]   pid_byte_i,
  input  wire logic [obdpr_pkg::RpmW-1:0]    engine_rpm_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]   road_speed_i,
  input  wire logic [obdpr_pkg::ThrW-1:0]    throttle_percent_i,
  input  wire logic [obdpr_pkg::ByteW-1:0]   coolant_temp_i,
  // result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic [obdpr_pkg::IdW-1:0]          frame_id_o,
  output logic [obdpr_pkg::ByteW-1:0]        data0_o,
  output logic [obdpr_pkg::ByteW-1:0]        data1_o,
  output logic [obdpr_pkg::ByteW-1:0]        data2_o,
  output logic [obdpr_pkg::ByteW-1:0]        data3_o,
  output logic [obdpr_pkg::ByteW-1:0]        data4_o,
  output logic [obdpr_pkg::ByteW-1:0]        data5_o,
  output logic [obdpr_pkg::ByteW-1:0]        data6_o,
  output logic [obdpr_pkg::ByteW-1:0]        data7_o,
  output logic                               last_of_run_o,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [obdpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [obdpr_pkg::CfgW-1:0]    cfg_wdata_i
);
  import obdpr_pkg::*;

  logic [IdW-1:0]     func_id_q, phys_id_q, reply_id_q;
  logic [PeriodW-1:0] eng_period_q, veh_period_q, body_period_q;
  logic               accept, fe_push, be_pop, out_valid;
  cmd_t               fe_cmd, q_head;
  q_stat_t            q_stat;
  logic [ByteW-1:0]   data [8];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_id_q     <= FUNC_ID_RST;
      phys_id_q     <= PHYS_ID_RST;
      reply_id_q    <= REPLY_ID_RST;
      eng_period_q  <= ENG_PERIOD_RST;
      veh_period_q  <= VEH_PERIOD_RST;
      body_period_q <= BODY_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FUNC_ID:     func_id_q     <= cfg_wdata_i[IdW-1:0];
        CFG_PHYS_ID:     phys_id_q     <= cfg_wdata_i[IdW-1:0];
        CFG_REPLY_ID:    reply_id_q    <= cfg_wdata_i[IdW-1:0];
        CFG_ENG_PERIOD:  eng_period_q  <= cfg_wdata_i[PeriodW-1:0];
        CFG_VEH_PERIOD:  veh_period_q  <= cfg_wdata_i[PeriodW-1:0];
        CFG_BODY_PERIOD: body_period_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  obdpr_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .kind_i             (kind_i),
    .can_id_i           (can_id_i),
    .frame_len_i        (frame_len_i),
    .mode_byte_i        (mode_byte_i),
    .pid_byte_i         (pid_byte_i),
    .engine_rpm_i       (engine_rpm_i),
    .road_speed_i       (road_speed_i),
    .throttle_percent_i (throttle_percent_i),
    .coolant_temp_i     (coolant_temp_i),
    .func_id_i          (func_id_q),
    .phys_id_i          (phys_id_q),
    .eng_period_i       (eng_period_q),
    .veh_period_i       (veh_period_q),
    .body_period_i      (body_period_q),
    .push_o             (fe_push),
    .cmd_o              (fe_cmd)
  );

  obdpr_cmdq #(
    .Depth (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_cmd),
    .pop_i   (be_pop),
    .rdata_o (q_head),
    .stat_o  (q_stat)
  );

  obdpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_head),
    .cmd_empty_i (q_stat.empty),
    .cmd_pop_o   (be_pop),
    .reply_id_i  (reply_id_q),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .frame_id_o  (frame_id_o),
    .data_o      (data),
    .last_o      (last_of_run_o)
  );

  assign empty   = !out_valid;
  assign data0_o = data[0];
  assign data1_o = data[1];
  assign data2_o = data[2];
  assign data3_o = data[3];
  assign data4_o = data[4];
  assign data5_o = data[5];
  assign data6_o = data[6];
  assign data7_o = data[7];

  // Checks
  a_q_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("command queue both full and empty");

  a_data7_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (data7_o == '0))
    else $error("data byte 7 not zero");

  a_mid_run_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_of_run_o) |-> (frame_id_o == ID_ENGINE || frame_id_o == ID_VEHICLE))
    else $error("non-final frame is not an engine or vehicle broadcast");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    be_pop |-> !q_stat.empty)
    else $error("frame builder consumed from an empty queue");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OBD mode 01 PID responder. Requests and
// millisecond ticks go in through the push/full queue port; the frames that
// come out through empty/pop are checked field by field against a predictor
// that tracks the request ids, the reply id and the three broadcast timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import obdpr_pkg::*;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // register indexes past the end of the map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CFG_BODY_PERIOD + 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = '1;

  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic               kind;
    logic [IdW-1:0]     can_id;
    logic [LenW-1:0]    frame_len;
    logic [ByteW-1:0]   mode;
    logic [ByteW-1:0]   pid;
    logic [RpmW-1:0]    rpm;
    logic [ByteW-1:0]   speed;
    logic [ThrW-1:0]    throttle;
    logic [ByteW-1:0]   coolant;
  } obd_request_t;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic [7:0][ByteW-1:0]   data;
    logic                    last;
  } can_frame_t;

  // Predicts the frames each request causes and matches them in order
  class frame_scoreboard;
    logic [IdW-1:0]     func_id;
    logic [IdW-1:0]     phys_id;
    logic [IdW-1:0]     reply_id;
    logic [PeriodW-1:0] period [3];
    logic [15:0]        elapsed [3];
    can_frame_t         pending [$];
    int                 mismatches;

    function void reset_state();
      func_id = FUNC_ID_RST;
      phys_id = PHYS_ID_RST;
      reply_id = REPLY_ID_RST;
      period[BC_ENGINE] = ENG_PERIOD_RST;
      period[BC_VEHICLE] = VEH_PERIOD_RST;
      period[BC_BODY] = BODY_PERIOD_RST;
      foreach (elapsed[i]) elapsed[i] = '0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_FUNC_ID:     func_id = val[IdW-1:0];
        CFG_PHYS_ID:     phys_id = val[IdW-1:0];
        CFG_REPLY_ID:    reply_id = val[IdW-1:0];
        CFG_ENG_PERIOD:  period[BC_ENGINE] = val[PeriodW-1:0];
        CFG_VEH_PERIOD:  period[BC_VEHICLE] = val[PeriodW-1:0];
        CFG_BODY_PERIOD: period[BC_BODY] = val[PeriodW-1:0];
        default: ;
      endcase
    endfunction

    // saturating count, restart on reaching the period
    function bit timer_fires(int n);
      if (elapsed[n] != '1) elapsed[n] = elapsed[n] + 16'd1;
      if (elapsed[n] >= period[n]) begin
        elapsed[n] = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(obd_request_t r);
      logic [15:0]      rpm4;
      logic [15:0]      centi;
      logic [ByteW-1:0] cool_b;
      logic [ByteW-1:0] thr_b;
      can_frame_t       run [3];
      int               n;
      rpm4 = {r.rpm[13:0], 2'b00};
      cool_b = r.coolant + COOLANT_OFS;
      thr_b = 8'((int'(r.throttle) * 255) / 100);
      centi = 16'(int'(r.speed) * 100);
      n = 0;
      if (r.kind == KIND_FRAME) begin
        if (r.can_id != func_id && r.can_id != phys_id) return;
        if (r.frame_len < MIN_REQ_LEN || r.mode != MODE_CUR_DATA) return;
        run[0] = '0;
        run[0].id = reply_id;
        run[0].data[1] = MODE_REPLY;
        run[0].data[2] = r.pid;
        run[0].last = 1'b1;
        case (r.pid)
          PID_SUPPORTED: begin
            run[0].data[0] = 8'd6;
            run[0].data[3] = SUPP_B0;
            run[0].data[4] = SUPP_B1;
            run[0].data[5] = SUPP_B2;
            run[0].data[6] = SUPP_B3;
          end
          PID_COOLANT: begin
            run[0].data[0] = 8'd3;
            run[0].data[3] = cool_b;
          end
          PID_RPM: begin
            run[0].data[0] = 8'd4;
            run[0].data[3] = rpm4[15:8];
            run[0].data[4] = rpm4[7:0];
          end
          PID_VSS: begin
            run[0].data[0] = 8'd3;
            run[0].data[3] = r.speed;
          end
          PID_TPS: begin
            run[0].data[0] = 8'd3;
            run[0].data[3] = thr_b;
          end
          default: return;
        endcase
        pending.push_back(run[0]);
        return;
      end
      // tick: broadcasts in engine, vehicle, body order
      if (timer_fires(BC_ENGINE)) begin
        run[n] = '0;
        run[n].id = ID_ENGINE;
        run[n].data[0] = rpm4[15:8];
        run[n].data[1] = rpm4[7:0];
        run[n].data[2] = cool_b;
        run[n].data[3] = thr_b;
        n++;
      end
      if (timer_fires(BC_VEHICLE)) begin
        run[n] = '0;
        run[n].id = ID_VEHICLE;
        run[n].data[0] = centi[15:8];
        run[n].data[1] = centi[7:0];
        run[n].data[2] = 8'(r.speed != 8'd0);
        n++;
      end
      if (timer_fires(BC_BODY)) begin
        run[n] = '0;
        run[n].id = ID_BODY;
        run[n].data[0] = 8'(r.speed == 8'd0);
        run[n].data[1] = 8'(r.speed != 8'd0);
        n++;
      end
      if (n > 0) run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(run[i]);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < 40)
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_frame(can_frame_t got);
      can_frame_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected frame, id", got.id, 0);
        return;
      end
      want = pending.pop_front();
      if (got.id != want.id) report_mismatch("frame_id", got.id, want.id);
      for (int i = 0; i < 8; i++)
        if (got.data[i] != want.data[i])
          report_mismatch($sformatf("data%0d", i), got.data[i], want.data[i]);
      if (got.last != want.last) report_mismatch("last_of_run", got.last, want.last);
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  obd_request_t     req_q = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [IdW-1:0]   frame_id_o;
  logic [ByteW-1:0] data0_o, data1_o, data2_o, data3_o;
  logic [ByteW-1:0] data4_o, data5_o, data6_o, data7_o;
  logic             last_of_run_o;
  logic             cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  can_frame_t       seen;

  frame_scoreboard  sb = new();
  int               send_idle_pct = 35;
  int               recv_idle_pct = 48;
  int               hold_seq = 0;
  int               hold_seen = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  assign seen = {frame_id_o, data7_o, data6_o, data5_o, data4_o,
                 data3_o, data2_o, data1_o, data0_o, last_of_run_o};

  obd_pid_responder_with_broadcasts_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .kind_i             (req_q.kind),
    .can_id_i           (req_q.can_id),
    .frame_len_i        (req_q.frame_len),
    .mode_byte_i        (req_q.mode),
    .pid_byte_i         (req_q.pid),
    .engine_rpm_i       (req_q.rpm),
    .road_speed_i       (req_q.speed),
    .throttle_percent_i (req_q.throttle),
    .coolant_temp_i     (req_q.coolant),
    .empty              (empty),
    .pop                (pop),
    .frame_id_o         (frame_id_o),
    .data0_o            (data0_o),
    .data1_o            (data1_o),
    .data2_o            (data2_o),
    .data3_o            (data3_o),
    .data4_o            (data4_o),
    .data5_o            (data5_o),
    .data6_o            (data6_o),
    .data7_o            (data7_o),
    .last_of_run_o      (last_of_run_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Result side: check accepted frames, then choose next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_frame(seen);
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles without any accepted request or frame
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic obd_request_t make_request(logic kind, logic [IdW-1:0] id,
                                                logic [LenW-1:0] len,
                                                logic [ByteW-1:0] mode,
                                                logic [ByteW-1:0] pid);
    obd_request_t r;
    r.kind = kind;
    r.can_id = id;
    r.frame_len = len;
    r.mode = mode;
    r.pid = pid;
    r.rpm = 16'($urandom);
    r.speed = 8'($urandom);
    r.throttle = 7'($urandom_range(0, 100));
    r.coolant = 8'($urandom);
    return r;
  endfunction

  // Mostly well-formed requests and ticks, some broken requests and noise
  function automatic obd_request_t random_request();
    obd_request_t r;
    int           roll;
    r = make_request(KIND_FRAME, 11'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
    roll = $urandom_range(99);
    if (roll < 40) begin
      r.kind = KIND_TICK;
    end else if (roll < 90) begin
      r.can_id = ($urandom_range(1) != 0) ? sb.func_id : sb.phys_id;
      r.frame_len = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(3, 8));
      r.mode = MODE_CUR_DATA;
      case ($urandom_range(4))
        0: r.pid = PID_SUPPORTED;
        1: r.pid = PID_COOLANT;
        2: r.pid = PID_RPM;
        3: r.pid = PID_VSS;
        default: r.pid = PID_TPS;
      endcase
      // break one field now and then
      if (roll >= 80) begin
        case ($urandom_range(3))
          0: r.can_id = 11'($urandom);
          1: r.frame_len = 4'($urandom_range(0, 2));
          2: r.mode = 8'($urandom);
          default: r.pid = 8'($urandom);
        endcase
      end
    end
    if ($urandom_range(9) == 0) r.throttle = 7'($urandom_range(101, 127));
    if ($urandom_range(4) == 0) r.speed = '0;
    return r;
  endfunction

  // Offer one request, with random gaps ahead of it, until it is taken
  task automatic send_request(obd_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_q <= r;
    do @(posedge clk_i); while (full);
    sb.note_request(r);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Drain everything, let the block go quiet, then load all registers
  task automatic apply_setting(logic [CfgW-1:0] func, logic [CfgW-1:0] phys,
                               logic [CfgW-1:0] reply, logic [CfgW-1:0] eng,
                               logic [CfgW-1:0] veh, logic [CfgW-1:0] body);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_cfg(CFG_FUNC_ID, func);
    write_cfg(CFG_PHYS_ID, phys);
    write_cfg(CFG_REPLY_ID, reply);
    write_cfg(CFG_ENG_PERIOD, eng);
    write_cfg(CFG_VEH_PERIOD, veh);
    write_cfg(CFG_BODY_PERIOD, body);
    if ($urandom_range(1) != 0) write_cfg(CFG_SPARE_LO, 16'($urandom));
    else write_cfg(CFG_SPARE_HI, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 12)));
    repeat (count) send_request(random_request());
  endtask

  // Fixed corner cases on reset settings
  task automatic run_directed();
    obd_request_t r;
    r = make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, PID_SUPPORTED);
    send_request(r);
    r = make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, PID_COOLANT);
    r.coolant = 8'hFF;
    send_request(r);
    r.coolant = 8'h00;
    send_request(r);
    r = make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, PID_RPM);
    r.rpm = 16'hFFFF;
    send_request(r);
    r = make_request(KIND_FRAME, PHYS_ID_RST, 4'd3, MODE_CUR_DATA, PID_RPM);
    r.rpm = 16'h0000;
    send_request(r);
    r = make_request(KIND_FRAME, PHYS_ID_RST, 4'd5, MODE_CUR_DATA, PID_VSS);
    r.speed = 8'hFF;
    send_request(r);
    r.speed = 8'h00;
    send_request(r);
    r = make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, PID_TPS);
    r.throttle = 7'd100;
    send_request(r);
    r.throttle = 7'd127;
    send_request(r);
    r.throttle = 7'd0;
    send_request(r);
    // length field above 8 still counts as long enough
    r = make_request(KIND_FRAME, FUNC_ID_RST, 4'd15, MODE_CUR_DATA, PID_VSS);
    send_request(r);
    // requests that must be ignored
    send_request(make_request(KIND_FRAME, FUNC_ID_RST, 4'd2, MODE_CUR_DATA, PID_RPM));
    send_request(make_request(KIND_FRAME, PHYS_ID_RST, 4'd0, MODE_CUR_DATA, PID_RPM));
    send_request(make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_REPLY, PID_RPM));
    send_request(make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, 8'hFF, PID_VSS));
    send_request(make_request(KIND_FRAME, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, 8'hFF));
    send_request(make_request(KIND_FRAME, PHYS_ID_RST, 4'd8, MODE_CUR_DATA, 8'h06));
    send_request(make_request(KIND_FRAME, 11'h7FF, 4'd8, MODE_CUR_DATA, PID_RPM));
    send_request(make_request(KIND_FRAME, 11'h000, 4'd8, MODE_CUR_DATA, PID_RPM));
    // ticks carrying request fields that must not matter
    send_request(make_request(KIND_TICK, FUNC_ID_RST, 4'd8, MODE_CUR_DATA, PID_RPM));
    send_request(make_request(KIND_TICK, 11'h7FF, 4'hF, 8'hFF, 8'hFF));
  endtask

  // Extreme settings: ids at both ends, periods of zero, one and the maximum
  task automatic run_extremes();
    obd_request_t r;
    apply_setting(16'hF800, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    send_request(make_request(KIND_FRAME, 11'h000, 4'd8, MODE_CUR_DATA, PID_RPM));
    send_request(make_request(KIND_FRAME, 11'h7FF, 4'd4, MODE_CUR_DATA, PID_SUPPORTED));
    r = make_request(KIND_TICK, 11'h000, 4'd0, 8'h00, 8'h00);
    r.speed = 8'h00;
    r.rpm = 16'hFFFF;
    send_request(r);
    r.speed = 8'hFF;
    r.throttle = 7'd127;
    send_request(r);
    r.coolant = 8'hFF;
    send_request(r);
    // lowering a period below the count fires on the next tick
    apply_setting(16'h07DF, 16'h0000, 16'h0001, 16'hFFFF, 16'd2, 16'd3);
    repeat (4) send_request(make_request(KIND_TICK, 11'h7FF, 4'hF, 8'hFF, 8'hFF));
  endtask

  initial begin
    sb.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles more lightly than the receiver
    send_idle_pct = 35;
    recv_idle_pct = 48;
    run_directed();
    run_extremes();
    run_random(10);
    run_random(10);

    // roles swapped; receiver holds off while every tick emits three frames
    send_idle_pct = 48;
    recv_idle_pct = 35;
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd0);
    hold_seq <= hold_seq + 1;
    repeat (16) send_request(random_request());
    run_random(10);
    run_random(10);

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(8);
    run_random(8);

    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/obdpr_pkg.sv
rtl/core/obdpr_cmdq.sv
rtl/core/obdpr_front.sv
rtl/core/obdpr_back.sv
rtl/core/obd_pid_responder_with_broadcasts_top.sv
dv/tb.sv
